### hdl/smpwm_pkg.sv
package smpwm_pkg;

   // Channel organization
   localparam int NUM_CHANNELS = 24;
   localparam int GROUP_SIZE   = 8;
   localparam int NUM_GROUPS   = 3;
   localparam int DUTY_W       = 8;
   localparam int PHASE_W      = 10;
   localparam int CHAN_W       = 5;

   // Timing constants
   localparam int PERIOD_TICKS_DEFAULT = 1000;
   localparam int EDGE_DELAY           = 25;
   localparam logic [DUTY_W-1:0] DUTY_WINDOW = 8'd100;
   localparam logic [DUTY_W-1:0] DUTY_RESET  = 8'd50;

   // Phase at which each group drives its outputs high
   localparam logic [PHASE_W-1:0] GROUP_START [NUM_GROUPS] = '{10'd0, 10'd400, 10'd800};

   // Command characters
   localparam logic [7:0] CHAR_FIRST_CH = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_LAST_CH  = 8'h58;  // 'X'
   localparam logic [7:0] CHAR_HASH     = 8'h23;  // '#'
   localparam logic [7:0] CHAR_ENABLE   = 8'h45;  // 'E'
   localparam logic [7:0] CHAR_DISABLE  = 8'h44;  // 'D'

   // Kind of input transaction
   typedef enum logic {
      OP_TICK = 1'b0,
      OP_BYTE = 1'b1
   } opcode_type;

   // Command parser state
   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_DUTY   = 3'b010,
      MODE_ENABLE = 3'b100
   } parse_mode_type;

   // Duty table write from the parser to the generator
   typedef struct packed {
      logic                 we;
      logic [CHAN_W-1:0]    idx;
      logic [DUTY_W-1:0]    value;
   } duty_wr_type;

endpackage

### hdl/smpwm_cmd.sv
module smpwm_cmd (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_fire,
   input  logic [7:0]            rx_byte,
   output smpwm_pkg::duty_wr_type duty_wr,
   output logic                  enable,
   output logic                  enable_next
);

   smpwm_pkg::parse_mode_type    mode_ff, mode_in;
   logic [smpwm_pkg::CHAN_W-1:0] chan_ff, chan_in;
   logic                         enable_ff, enable_in;
   logic [7:0]                   chan_diff;

   assign chan_diff = rx_byte - smpwm_pkg::CHAR_FIRST_CH;

   // Decode one received byte
   always_comb begin
      mode_in   = mode_ff;
      chan_in   = chan_ff;
      enable_in = enable_ff;
      duty_wr   = '0;
      if (byte_fire) begin
         case (mode_ff)
            smpwm_pkg::MODE_DUTY: begin
               duty_wr.we    = (chan_ff < smpwm_pkg::CHAN_W'(smpwm_pkg::NUM_CHANNELS));
               duty_wr.idx   = chan_ff;
               duty_wr.value = rx_byte;
               mode_in       = smpwm_pkg::MODE_IDLE;
            end
            smpwm_pkg::MODE_ENABLE: begin
               if (rx_byte == smpwm_pkg::CHAR_ENABLE) begin
                  enable_in = 1'b1;
               end else if (rx_byte == smpwm_pkg::CHAR_DISABLE) begin
                  enable_in = 1'b0;
               end
               mode_in = smpwm_pkg::MODE_IDLE;
            end
            default: begin
               mode_in = smpwm_pkg::MODE_IDLE;
               if (rx_byte >= smpwm_pkg::CHAR_FIRST_CH &&
                   rx_byte <= smpwm_pkg::CHAR_LAST_CH) begin
                  chan_in = chan_diff[smpwm_pkg::CHAN_W-1:0];
                  mode_in = smpwm_pkg::MODE_DUTY;
               end else if (rx_byte == smpwm_pkg::CHAR_HASH) begin
                  mode_in = smpwm_pkg::MODE_ENABLE;
               end
            end
         endcase
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= smpwm_pkg::MODE_IDLE;
         chan_ff   <= '0;
         enable_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         chan_ff   <= chan_in;
         enable_ff <= enable_in;
      end
   end

   assign enable      = enable_ff;
   assign enable_next = enable_in;

endmodule

### hdl/smpwm_gen.sv
module smpwm_gen #(
   parameter int PERIOD_TICKS = smpwm_pkg::PERIOD_TICKS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   tick_fire,
   input  logic                                   enable,
   input  smpwm_pkg::duty_wr_type                 duty_wr,
   output logic [smpwm_pkg::NUM_CHANNELS-1:0]     levels_next
);

   localparam int PW = smpwm_pkg::PHASE_W;

   logic [smpwm_pkg::DUTY_W-1:0]       duty_ff [smpwm_pkg::NUM_CHANNELS];
   logic [PW-1:0]                      phase_ff, phase_in;
   logic [smpwm_pkg::NUM_CHANNELS-1:0] level_ff, level_in;
   logic                               advance;
   logic [PW:0]                        phase_inc;

   assign advance   = tick_fire && enable;
   assign phase_inc = {1'b0, phase_ff} + (PW+1)'(1);

   // Set groups at their start, clear in-window channels at duty edge
   always_comb begin
      logic [PW:0] edge_at;
      edge_at  = '0;
      level_in = level_ff;
      phase_in = phase_ff;
      if (advance) begin
         for (int g = 0; g < smpwm_pkg::NUM_GROUPS; g++) begin
            if (phase_ff == smpwm_pkg::GROUP_START[g]) begin
               level_in[g*smpwm_pkg::GROUP_SIZE +: smpwm_pkg::GROUP_SIZE] = '1;
            end
            for (int c = 0; c < smpwm_pkg::GROUP_SIZE; c++) begin
               edge_at = {1'b0, smpwm_pkg::GROUP_START[g]}
                         + (PW+1)'(smpwm_pkg::EDGE_DELAY)
                         + (PW+1)'(duty_ff[g*smpwm_pkg::GROUP_SIZE + c]);
               if (duty_ff[g*smpwm_pkg::GROUP_SIZE + c] <= smpwm_pkg::DUTY_WINDOW &&
                   {1'b0, phase_ff} == edge_at) begin
                  level_in[g*smpwm_pkg::GROUP_SIZE + c] = 1'b0;
               end
            end
         end
         // Wrap at the end of the period
         if (phase_inc >= (PW+1)'(PERIOD_TICKS)) begin
            phase_in = '0;
         end else begin
            phase_in = phase_inc[PW-1:0];
         end
      end
   end

   // Hold phase, levels and duty table
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         level_ff <= '0;
         for (int i = 0; i < smpwm_pkg::NUM_CHANNELS; i++) begin
            duty_ff[i] <= smpwm_pkg::DUTY_RESET;
         end
      end else begin
         phase_ff <= phase_in;
         level_ff <= level_in;
         if (duty_wr.we) begin
            duty_ff[duty_wr.idx] <= duty_wr.value;
         end
      end
   end

   assign levels_next = level_in;

endmodule

### hdl/staggered_multichannel_pwm_top.sv
// Pipeline: a result passes the input register, then the result register, and is held
//   there until rsp_tready takes it.
// Throughput: one transaction per cycle unless a result is held; each tick or byte is
//   fully handled by the parallel compares and parser logic between the two registers.
// Reset: synchronous, active high; clears the pipeline, phase, levels and parser,
//   and loads every duty value with 50.
module staggered_multichannel_pwm_top #(
   parameter int PERIOD_TICKS = smpwm_pkg::PERIOD_TICKS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [23:0] channel_levels, [24] running, [31:25] zero
);

   logic                               in_vld_ff;
   smpwm_pkg::opcode_type              in_op_ff;
   logic [7:0]                         in_byte_ff;
   logic                               out_vld_ff;
   logic [smpwm_pkg::NUM_CHANNELS-1:0] out_levels_ff;
   logic                               out_run_ff;
   logic                               out_ready;
   logic                               fire;
   logic                               tick_fire;
   logic                               byte_fire;
   smpwm_pkg::duty_wr_type             duty_wr;
   logic                               enable;
   logic                               enable_next;
   logic [smpwm_pkg::NUM_CHANNELS-1:0] levels_next;

   // Pipeline handshake
   assign out_ready  = !out_vld_ff || rsp_tready;
   assign fire       = in_vld_ff && out_ready;
   assign req_tready = !in_vld_ff || out_ready;
   assign tick_fire  = fire && (in_op_ff == smpwm_pkg::OP_TICK);
   assign byte_fire  = fire && (in_op_ff == smpwm_pkg::OP_BYTE);

   // Capture the input transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= smpwm_pkg::opcode_type'(req_tuser);
         in_byte_ff <= req_tdata;
      end
   end

   smpwm_cmd u_cmd (
      .clock       (clock),
      .reset       (reset),
      .byte_fire   (byte_fire),
      .rx_byte     (in_byte_ff),
      .duty_wr     (duty_wr),
      .enable      (enable),
      .enable_next (enable_next)
   );

   smpwm_gen #(
      .PERIOD_TICKS (PERIOD_TICKS)
   ) u_gen (
      .clock       (clock),
      .reset       (reset),
      .tick_fire   (tick_fire),
      .enable      (enable),
      .duty_wr     (duty_wr),
      .levels_next (levels_next)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_ready) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_levels_ff <= levels_next;
         out_run_ff    <= enable_next;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_run_ff, out_levels_ff};

endmodule

### hdl/smpwm_checker.sv
module smpwm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Input stalls only while a result is held back
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled with free result register");

   // Padding bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31:25] == 7'd0))
      else $error("result padding not zero");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind staggered_multichannel_pwm_top smpwm_checker u_checker (.*);
